// ----- sv/bsr_pkg.sv -----
// Package for the Babylonian square root core: widths, step and condition
// codes, the control word type and the microcode table.
// Depends on nothing; imported by bsr_div, babylonian_square_root_core and the bench.
package bsr_pkg;

	localparam int FRAC_BITS = 16;
	localparam int INT_BITS  = 16;
	localparam int RAD_W     = INT_BITS + FRAC_BITS;
	localparam int ROOT_W    = INT_BITS / 2 + FRAC_BITS + 1;
	localparam int DIV_W     = RAD_W + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_W);
	localparam int TOL_W     = 16;
	localparam int LIM_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [RAD_W-1:0]     ONE_FX       = RAD_W'(1) << FRAC_BITS;
	localparam logic [CNT_W-1:0]     DIV_LAST     = CNT_W'(DIV_W - 1);
	localparam logic [CFG_IDX_W-1:0] REG_TOL      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ITER_LIM = CFG_IDX_W'(1);
	localparam logic [TOL_W-1:0]     TOL_RESET    = TOL_W'(1);
	localparam logic [LIM_W-1:0]     LIM_RESET    = LIM_W'(32);

	// program steps
	localparam logic [2:0] STEP_IDLE = 3'd0;
	localparam logic [2:0] STEP_TEST = 3'd1;
	localparam logic [2:0] STEP_AVG  = 3'd2;
	localparam logic [2:0] STEP_DIV  = 3'd3;
	localparam logic [2:0] STEP_WB   = 3'd4;
	localparam logic [2:0] STEP_EMIT = 3'd7;

	// jump conditions
	localparam logic [2:0] COND_NONE     = 3'd0;
	localparam logic [2:0] COND_ALWAYS   = 3'd1;
	localparam logic [2:0] COND_NO_INPUT = 3'd2;
	localparam logic [2:0] COND_STOP     = 3'd3;
	localparam logic [2:0] COND_DIV_BUSY = 3'd4;
	localparam logic [2:0] COND_OUT_FULL = 3'd5;

	typedef struct packed {
		logic       init;
		logic       avg;
		logic       div;
		logic       ld_y;
		logic       emit;
		logic [2:0] cond;
		logic [2:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic start;
		logic step;
	} div_ctl_t;

	function automatic ctrl_word_t ucode(input logic [2:0] pc);
		ctrl_word_t w;
		w = '{init: 1'b0, avg: 1'b0, div: 1'b0, ld_y: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, target: STEP_IDLE};
		case (pc)
			STEP_IDLE: begin
				w.init   = 1'b1;
				w.cond   = COND_NO_INPUT;
				w.target = STEP_IDLE;
			end
			STEP_TEST: begin
				w.cond   = COND_STOP;
				w.target = STEP_EMIT;
			end
			STEP_AVG: begin
				w.avg  = 1'b1;
				w.cond = COND_NONE;
			end
			STEP_DIV: begin
				w.div    = 1'b1;
				w.cond   = COND_DIV_BUSY;
				w.target = STEP_DIV;
			end
			STEP_WB: begin
				w.ld_y   = 1'b1;
				w.cond   = COND_ALWAYS;
				w.target = STEP_TEST;
			end
			STEP_EMIT: begin
				w.emit   = 1'b1;
				w.cond   = COND_OUT_FULL;
				w.target = STEP_EMIT;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = STEP_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// ----- sv/bsr_div.sv -----
// Restoring bit-serial divider: one quotient bit per cycle while ctl.step is high.
// Depends on bsr_pkg; instantiated by babylonian_square_root_core.
module bsr_div import bsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DIV_W-1:0] dividend,
	input  logic [RAD_W-1:0] divisor,
	output logic [DIV_W-1:0] quotient,
	output logic             last
);

	logic [DIV_W-1:0] quo_q;
	logic [RAD_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W:0]   trial;
	logic [RAD_W:0]   diff;
	logic             fits;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign fits  = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.start) begin
			cnt_q <= '0;
		end else if (ctl.step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (ctl.step) begin
			quo_q <= {quo_q[DIV_W-2:0], fits};
			rem_q <= fits ? diff[RAD_W-1:0] : trial[RAD_W-1:0];
		end
	end

	assign quotient = quo_q;
	assign last     = cnt_q == DIV_LAST;

endmodule

// ----- sv/babylonian_square_root_core.sv -----
// Babylonian square root core, unsigned Q16.16 in, unsigned Q9.16 out, run by microcode.
// Steps: IDLE, TEST, then per iteration AVG, DIV, WB and TEST again (at most
// iteration_limit iterations), then EMIT; the serial divider dominates each
// iteration. One item at a time; next input beat the cycle after the emit.
// Reset: tolerance 1, iteration_limit 32, sequencer idle, no result pending.
// Depends on bsr_pkg and bsr_div.
module babylonian_square_root_core import bsr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [RAD_W-1:0]     radicand,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [ROOT_W-1:0]    root,
	output logic                 capped
);

	logic [2:0]        pc_q;
	logic [2:0]        pc_d;
	logic [TOL_W-1:0]  tol_q;
	logic [LIM_W-1:0]  lim_q;
	logic [LIM_W-1:0]  it_q;
	logic [RAD_W-1:0]  n_q;
	logic [RAD_W-1:0]  x_q;
	logic [DIV_W-1:0]  y_q;
	logic              out_valid_q;
	logic [ROOT_W-1:0] root_q;
	logic              capped_q;

	ctrl_word_t        cw;
	div_ctl_t          dctl;
	logic [DIV_W-1:0]  quotient;
	logic              div_last;
	logic [TOL_W-1:0]  tol_eff;
	logic [DIV_W:0]    diff;
	logic              keep;
	logic [DIV_W:0]    sum;
	logic              out_full;
	logic              accept;
	logic              do_emit;
	logic              take;

	assign cw        = ucode(pc_q);
	assign cfg_ready = 1'b1;
	assign in_ready  = cw.init;
	assign accept    = in_valid && in_ready;
	assign out_full  = out_valid_q && !out_ready;
	assign do_emit   = cw.emit && !out_full;

	assign tol_eff = (tol_q == '0) ? TOL_W'(1) : tol_q;
	assign diff    = {1'b0, {FRAC_BITS{1'b0}}, x_q} - {1'b0, y_q};
	assign keep    = !diff[DIV_W] && (diff[DIV_W-1:0] > DIV_W'(tol_eff));
	assign sum     = {1'b0, {FRAC_BITS{1'b0}}, x_q} + {1'b0, y_q};

	always_comb begin
		case (cw.cond)
			COND_NONE:     take = 1'b0;
			COND_ALWAYS:   take = 1'b1;
			COND_NO_INPUT: take = !in_valid;
			COND_STOP:     take = !keep || (it_q >= lim_q);
			COND_DIV_BUSY: take = !div_last;
			COND_OUT_FULL: take = out_full;
			default:       take = 1'b1;
		endcase
		pc_d = take ? cw.target : pc_q + 3'd1;
	end

	assign dctl.start = cw.avg;
	assign dctl.step  = cw.div;

	bsr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (dctl),
		.dividend ({n_q, {FRAC_BITS{1'b0}}}),
		.divisor  (x_q),
		.quotient (quotient),
		.last     (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= STEP_IDLE;
			tol_q       <= TOL_RESET;
			lim_q       <= LIM_RESET;
			it_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TOL:      tol_q <= cfg_data;
					REG_ITER_LIM: lim_q <= cfg_data[LIM_W-1:0];
					default:      ;
				endcase
			end
			if (accept) begin
				it_q <= '0;
			end else if (cw.avg) begin
				it_q <= it_q + LIM_W'(1);
			end
			if (do_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			n_q <= radicand;
			if (radicand >= ONE_FX) begin
				x_q <= radicand;
				y_q <= DIV_W'(ONE_FX);
			end else begin
				x_q <= ONE_FX;
				y_q <= DIV_W'(radicand);
			end
		end else begin
			if (cw.avg) begin
				x_q <= sum[RAD_W:1];
			end
			if (cw.ld_y) begin
				y_q <= quotient;
			end
		end
		if (do_emit) begin
			root_q   <= (x_q[RAD_W-1:ROOT_W] != '0) ? {ROOT_W{1'b1}} : x_q[ROOT_W-1:0];
			capped_q <= keep;
		end
	end

	assign out_valid = out_valid_q;
	assign root      = root_q;
	assign capped    = capped_q;

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == STEP_DIV |-> x_q != '0)
		else $error("divider running with zero divisor");

	a_avg_under_limit: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == STEP_AVG |-> it_q < lim_q)
		else $error("iteration started past the limit");

	a_accept_to_test: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q == STEP_TEST)
		else $error("input beat not followed by the test step");

	a_wb_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		pc_q == STEP_WB |-> $past(pc_q) == STEP_DIV && $past(div_last))
		else $error("quotient written back before the divider finished");

endmodule

// ----- bench/babylonian_square_root_core_tb.sv -----
// Self-checking bench for babylonian_square_root_core: directed and random radicands,
// register rewrites between batches, random idling and a long receiver stall.
// Depends on bsr_pkg and the core with its divider; no files or arguments.
`timescale 1ns / 100ps

module babylonian_square_root_core_tb import bsr_pkg::*; ();

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
	localparam logic [63:0]          ROOT_SAT    = (64'd1 << ROOT_W) - 64'd1;
	localparam int                   CYCLE_LIMIT = 20_000_000;
	localparam int                   HOLD_CYCLES = 4000;
	localparam int                   TAIL_CYCLES = 120;
	localparam int                   BATCH_ITEMS = 45;

	typedef struct packed {
		logic [ROOT_W-1:0] root;
		logic              capped;
	} root_result_t;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CFG_DAT_W-1:0] cfg_data   = '0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic [RAD_W-1:0]     radicand   = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [ROOT_W-1:0]    root;
	logic                 capped;

	logic [TOL_W-1:0]     model_tol  = TOL_RESET;
	logic [LIM_W-1:0]     model_lim  = LIM_RESET;
	root_result_t         pending_roots[$];
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   send_idle  = 0;
	int                   recv_idle  = 0;
	int                   hold_asked = 0;
	int                   hold_taken = 0;
	int                   hold_left  = 0;

	babylonian_square_root_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.radicand  (radicand),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.root      (root),
		.capped    (capped)
	);

	always #1 clk = ~clk;

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic root_result_t heron_root(input logic [RAD_W-1:0] n);
		logic [63:0]  x;
		logic [63:0]  y;
		logic [63:0]  tol;
		logic [63:0]  n_wide;
		int unsigned  steps;
		root_result_t res;
		n_wide = 64'(n);
		tol = (model_tol == '0) ? 64'd1 : 64'(model_tol);
		steps = 0;
		res.capped = 1'b0;
		if (n_wide >= 64'(ONE_FX)) begin
			x = n_wide;
			y = 64'(ONE_FX);
		end else begin
			x = 64'(ONE_FX);
			y = n_wide;
		end
		while (x > y && (x - y) > tol) begin
			if (steps >= int'(model_lim)) begin
				res.capped = 1'b1;
				break;
			end
			x = (x + y) >> 1;
			if (x == 64'd0)
				break;
			y = (n_wide << FRAC_BITS) / x;
			steps++;
		end
		res.root = (x > ROOT_SAT) ? ROOT_SAT[ROOT_W-1:0] : x[ROOT_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at cycle %0d, %s: got %0h, want %0h", cycle_count, what, got, want);
		mismatches++;
	endtask

	task automatic wait_until_idle();
		in_valid = 1'b0;
		while (pending_roots.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		wait_until_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TOL)
			model_tol = data[TOL_W-1:0];
		else if (idx == REG_ITER_LIM)
			model_lim = data[LIM_W-1:0];
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic send_radicand(input logic [RAD_W-1:0] value);
		while (roll(send_idle)) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		radicand = value;
		do @(posedge clk); while (!in_ready);
		pending_roots.push_back(heron_root(value));
		@(negedge clk);
	endtask

	function automatic logic [RAD_W-1:0] pick_radicand();
		logic [RAD_W-1:0] k;
		case ($urandom_range(5))
			0: return RAD_W'($urandom);
			1: return RAD_W'($urandom >> $urandom_range(31));
			2: return RAD_W'($urandom_range(65535));
			3: begin
				k = RAD_W'($urandom_range(255));
				return ((k * k) << FRAC_BITS) + RAD_W'($urandom_range(2));
			end
			4: return RAD_W'(32'h0000_FFF8 + $urandom_range(16));
			default: return RAD_W'(32'hFFFF_FFFF - $urandom_range(255));
		endcase
	endfunction

	task automatic pick_settings();
		logic [CFG_DAT_W-1:0] tol_data;
		logic [LIM_W-1:0]     lim;
		case ($urandom_range(9))
			0, 1, 2, 3: tol_data = CFG_DAT_W'(1);
			4, 5, 6:    tol_data = CFG_DAT_W'($urandom_range(2, 64));
			7:          tol_data = '0;
			default:    tol_data = CFG_DAT_W'($urandom_range(65535));
		endcase
		case ($urandom_range(9))
			0:       lim = LIM_W'($urandom_range(0, 8));
			1:       lim = LIM_W'($urandom_range(65, 127));
			default: lim = LIM_W'($urandom_range(16, 64));
		endcase
		write_reg(REG_TOL, tol_data);
		write_reg(REG_ITER_LIM, {9'($urandom_range(511)), lim});
		if (roll(15))
			write_reg(roll(50) ? REG_SPARE_A : REG_SPARE_B, CFG_DAT_W'($urandom));
	endtask

	task automatic test_reset_values();
		send_radicand(32'h0000_0000);
		send_radicand(32'h0000_0001);
		send_radicand(32'h0000_FFFF);
		send_radicand(32'h0001_0000);
		send_radicand(32'h0001_0001);
		send_radicand(32'h0004_0000);
		send_radicand(32'h8000_0000);
		send_radicand(32'h5555_5555);
		send_radicand(32'hAAAA_AAAA);
		send_radicand(32'hFFFF_FFFF);
	endtask

	task automatic test_no_iterations();
		write_reg(REG_ITER_LIM, 16'hFF80);
		send_radicand(32'h0001_0000);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_8000);
		send_radicand(32'h0000_0000);
	endtask

	task automatic test_short_limits();
		write_reg(REG_ITER_LIM, 16'h0001);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0000_0001);
		write_reg(REG_ITER_LIM, 16'h0002);
		send_radicand(32'h8000_0000);
		write_reg(REG_ITER_LIM, 16'h0008);
		send_radicand(32'hFFFF_FFFF);
	endtask

	task automatic test_tolerance_extremes();
		write_reg(REG_TOL, 16'h0000);
		write_reg(REG_ITER_LIM, 16'hFFFF);
		send_radicand(32'h0002_0000);
		send_radicand(32'h0000_0003);
		write_reg(REG_TOL, 16'hFFFF);
		send_radicand(32'hFFFF_FFFF);
		send_radicand(32'h0003_0000);
		write_reg(REG_TOL, 16'h5555);
		write_reg(REG_ITER_LIM, 16'h0040);
		send_radicand(32'hAAAA_AAAA);
		write_reg(REG_SPARE_A, 16'hFFFF);
		write_reg(REG_SPARE_B, 16'hAAAA);
		send_radicand(32'h1234_5678);
	endtask

	task automatic test_stalled_receiver();
		write_reg(REG_TOL, TOL_RESET);
		write_reg(REG_ITER_LIM, LIM_RESET);
		send_idle = 0;
		recv_idle = 0;
		hold_asked++;
		repeat (8) send_radicand(pick_radicand());
		wait_until_idle();
	endtask

	task automatic test_random_traffic();
		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 26 : (phase == 1) ? 50 : 0;
			recv_idle = (phase == 0) ? 50 : (phase == 1) ? 26 : 0;
			for (int batch = 0; batch < 4; batch++) begin
				pick_settings();
				repeat (BATCH_ITEMS) send_radicand(pick_radicand());
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = !roll(recv_idle);
		end
	end

	always @(posedge clk) begin : check_results
		root_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_roots.size() == 0) begin
				report_mismatch("result beat with nothing pending", 32'(root), 32'(capped));
			end else begin
				want = pending_roots.pop_front();
				if (root !== want.root)
					report_mismatch("root", 32'(root), 32'(want.root));
				if (capped !== want.capped)
					report_mismatch("capped", 32'(capped), 32'(want.capped));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		send_idle = 26;
		recv_idle = 50;
		test_reset_values();
		test_no_iterations();
		test_short_limits();
		test_tolerance_extremes();
		test_stalled_receiver();
		test_random_traffic();
		wait_until_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/bsr_pkg.sv
sv/bsr_div.sv
sv/babylonian_square_root_core.sv
bench/babylonian_square_root_core_tb.sv
